FILE: design/usbsrh_pkg.sv
// ----------------------------------------------------------------------------
// usbsrh_pkg
// Shared types and constants of the USB standard request handler: setup
// fields, result fields, request codes and configuration register indexes.
// ----------------------------------------------------------------------------
package usbsrh_pkg;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 4;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   // bmRequestType fields and values
   localparam logic [7:0] RTYPE_KIND_MASK = 8'h60;
   localparam logic [7:0] RTYPE_STANDARD  = 8'h00;
   localparam logic [7:0] RTYPE_VENDOR    = 8'h40;
   localparam logic [7:0] RTYPE_DEV_OUT   = 8'h00;
   localparam logic [7:0] RTYPE_EP_OUT    = 8'h02;
   localparam logic [7:0] RTYPE_DEV_IN    = 8'h80;
   localparam logic [7:0] RTYPE_IF_IN     = 8'h81;
   localparam logic [7:0] RTYPE_EP_IN     = 8'h82;

   // standard bRequest codes
   localparam logic [7:0] REQ_GET_STATUS    = 8'd0;
   localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
   localparam logic [7:0] REQ_SET_FEATURE   = 8'd3;
   localparam logic [7:0] REQ_SET_ADDRESS   = 8'd5;
   localparam logic [7:0] REQ_GET_DESC      = 8'd6;
   localparam logic [7:0] REQ_GET_CONFIG    = 8'd8;
   localparam logic [7:0] REQ_SET_CONFIG    = 8'd9;
   localparam logic [7:0] REQ_GET_INTF      = 8'd10;
   localparam logic [7:0] REQ_SET_INTF      = 8'd11;
   localparam logic [7:0] REQ_SYNCH_FRAME   = 8'd12;

   // descriptor types (high byte of wValue)
   localparam logic [7:0] DT_DEVICE = 8'd1;
   localparam logic [7:0] DT_CONFIG = 8'd2;
   localparam logic [7:0] DT_STRING = 8'd3;

   localparam logic [15:0] LANG_EN_US = 16'h0409;

   // descriptor kind codes on the result
   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_DEVICE   = 3'd1;
   localparam logic [2:0] KIND_CONFIG   = 3'd2;
   localparam logic [2:0] KIND_LANGUAGE = 3'd3;
   localparam logic [2:0] KIND_STRING   = 3'd4;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_VENDOR_READ  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VENDOR_CLEAR = 4'd1;

   localparam logic [7:0] VENDOR_READ_RESET  = 8'd1;
   localparam logic [7:0] VENDOR_CLEAR_RESET = 8'd2;

   typedef struct packed {
      logic [7:0]  request_type;
      logic [7:0]  request_code;
      logic [15:0] request_value;
      logic [15:0] request_index;
      logic [7:0]  overflow_count;
   } setup_type;

   typedef struct packed {
      logic       stall_control;
      logic [1:0] reply_length;
      logic [7:0] reply_first;
      logic [7:0] reply_second;
      logic [2:0] descriptor_kind;
      logic [7:0] descriptor_number;
      logic       clear_overflow;
      logic       reset_bulk_toggles;
   } result_type;

   typedef struct packed {
      logic [7:0] read_code;
      logic [7:0] clear_code;
   } vendor_cfg_type;

endpackage

FILE: design/usbsrh_csr.sv
// ----------------------------------------------------------------------------
// usbsrh_csr
// Vendor request code registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module usbsrh_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [usbsrh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [usbsrh_pkg::CSR_DATA_W-1:0]  csr_data,
   output usbsrh_pkg::vendor_cfg_type        cfg
);
   import usbsrh_pkg::*;

   logic [7:0] read_code_ff;
   logic [7:0] clear_code_ff;
   logic       csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         read_code_ff  <= VENDOR_READ_RESET;
         clear_code_ff <= VENDOR_CLEAR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_VENDOR_READ:  read_code_ff  <= csr_data;
            CSR_VENDOR_CLEAR: clear_code_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign cfg.read_code  = read_code_ff;
   assign cfg.clear_code = clear_code_ff;

endmodule

FILE: design/usbsrh_decode.sv
// ----------------------------------------------------------------------------
// usbsrh_decode
// Setup packet decode: result fields and next endpoint halt bits.
// ----------------------------------------------------------------------------
module usbsrh_decode #(
   parameter int ENDPOINT_COUNT = 7
) (
   input  usbsrh_pkg::setup_type        setup,
   input  usbsrh_pkg::vendor_cfg_type   cfg,
   input  logic [2*ENDPOINT_COUNT-1:0]  halt_cur,
   output usbsrh_pkg::result_type       result,
   output logic [2*ENDPOINT_COUNT-1:0]  halt_next
);
   import usbsrh_pkg::*;

   localparam int         HALT_W   = 2 * ENDPOINT_COUNT;
   localparam logic [3:0] EP_LIMIT = 4'(ENDPOINT_COUNT);

   logic [3:0]        ep_num;
   logic              ep_in;
   logic              ep_zero;
   logic              ep_bad;
   logic [HALT_W-1:0] ep_sel;
   logic [HALT_W-1:0] bulk_mask;
   logic              ep_halted;
   logic [7:0]        desc_type;
   logic [7:0]        desc_index;
   logic              stall;
   result_type        res;

   assign ep_num     = setup.request_index[3:0];
   assign ep_in      = setup.request_index[7];
   assign ep_zero    = (ep_num == 4'd0);
   assign ep_bad     = (ep_num > EP_LIMIT);
   assign desc_type  = setup.request_value[15:8];
   assign desc_index = setup.request_value[7:0];

   always_comb begin
      for (int n = 0; n < ENDPOINT_COUNT; n++) begin
         ep_sel[2*n]      = (ep_num == 4'(n + 1)) && !ep_in;
         ep_sel[2*n+1]    = (ep_num == 4'(n + 1)) && ep_in;
         bulk_mask[2*n]   = (n == 1);
         bulk_mask[2*n+1] = (n == 1);
      end
   end

   assign ep_halted = |(halt_cur & ep_sel);

   always_comb begin
      res       = '0;
      stall     = 1'b0;
      halt_next = halt_cur;
      if ((setup.request_type & RTYPE_KIND_MASK) == RTYPE_STANDARD) begin
         case (setup.request_code)
            REQ_GET_STATUS: begin
               if (setup.request_type == RTYPE_DEV_IN || setup.request_type == RTYPE_IF_IN) begin
                  res.reply_length = 2'd2;
               end else if (setup.request_type == RTYPE_EP_IN) begin
                  if (ep_bad) begin
                     stall = 1'b1;
                  end else begin
                     res.reply_length = 2'd2;
                     res.reply_first  = {7'd0, ep_halted};
                  end
               end else begin
                  stall = 1'b1;
               end
            end
            REQ_CLEAR_FEATURE: begin
               if (setup.request_type == RTYPE_DEV_OUT) begin
                  stall = 1'b1;
               end else if (setup.request_type == RTYPE_EP_OUT) begin
                  if (setup.request_value != 16'd0 || ep_bad) begin
                     stall = 1'b1;
                  end else begin
                     halt_next = halt_cur & ~ep_sel;
                  end
               end
            end
            REQ_SET_FEATURE: begin
               if (setup.request_type == RTYPE_EP_OUT) begin
                  if (setup.request_value != 16'd0 || ep_bad || ep_zero) begin
                     stall = 1'b1;
                  end else begin
                     halt_next = halt_cur | ep_sel;
                  end
               end
            end
            REQ_SET_ADDRESS, REQ_SET_CONFIG, REQ_SYNCH_FRAME: ;
            REQ_GET_DESC: begin
               case (desc_type)
                  DT_DEVICE: res.descriptor_kind = KIND_DEVICE;
                  DT_CONFIG: res.descriptor_kind = KIND_CONFIG;
                  DT_STRING: begin
                     if (setup.request_index == 16'd0 ||
                         (setup.request_index == LANG_EN_US && desc_index == 8'd0)) begin
                        res.descriptor_kind = KIND_LANGUAGE;
                     end else if (setup.request_index == LANG_EN_US) begin
                        res.descriptor_kind   = KIND_STRING;
                        res.descriptor_number = desc_index;
                     end else begin
                        stall = 1'b1;
                     end
                  end
                  default: stall = 1'b1;
               endcase
            end
            REQ_GET_CONFIG: begin
               res.reply_length = 2'd1;
               res.reply_first  = 8'd1;
            end
            REQ_GET_INTF: res.reply_length = 2'd1;
            REQ_SET_INTF: begin
               halt_next              = halt_cur & ~bulk_mask;
               res.reset_bulk_toggles = 1'b1;
            end
            default: stall = 1'b1;
         endcase
      end else if ((setup.request_type & RTYPE_KIND_MASK) == RTYPE_VENDOR) begin
         if (setup.request_code == cfg.read_code && setup.request_type[7]) begin
            res.reply_length = 2'd1;
            res.reply_first  = setup.overflow_count;
         end else if (setup.request_code == cfg.clear_code && !setup.request_type[7]) begin
            res.clear_overflow = 1'b1;
         end else begin
            stall = 1'b1;
         end
      end else begin
         stall = 1'b1;
      end

      if (stall) begin
         res = '0;
      end
      res.stall_control = stall;
   end

   assign result = res;

endmodule

FILE: design/usb_standard_request_handler.sv
// A setup beat goes from the input register through decode to the result register.
// One beat per cycle unless rsp_ stalls; halt bits update as a beat leaves decode.
// Backpressure on rsp_ holds the result register and then the input register.
// Reset (synchronous, active high) clears both valid flags, all endpoint halt bits,
// and loads the vendor read and clear codes with 1 and 2.
// ----------------------------------------------------------------------------
// usb_standard_request_handler
// USB standard and vendor control request handler with per-endpoint halt tracking.
// ----------------------------------------------------------------------------
module usb_standard_request_handler #(
   parameter int ENDPOINT_COUNT = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // request_type, request_code, request_value, request_index, overflow_count
   input  logic [usbsrh_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // reply_length, reply_first, reply_second, descriptor_number,
   // clear_overflow, reset_bulk_toggles, zero fill
   output logic [usbsrh_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // stall_control, descriptor_kind
   output logic [usbsrh_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [usbsrh_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [usbsrh_pkg::CSR_DATA_W-1:0]   csr_data
);
   import usbsrh_pkg::*;

   localparam int HALT_W = 2 * ENDPOINT_COUNT;

   logic              s1_valid_ff;
   logic              s1_valid_in;
   setup_type         s1_data_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   result_type        out_data_ff;
   logic [HALT_W-1:0] halt_ff;
   logic [HALT_W-1:0] halt_in;
   logic [HALT_W-1:0] halt_next;
   result_type        result;
   vendor_cfg_type    cfg;
   setup_type         req_setup;
   logic              req_accept;
   logic              s1_move;

   usbsrh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   usbsrh_decode #(
      .ENDPOINT_COUNT (ENDPOINT_COUNT)
   ) u_decode (
      .setup     (s1_data_ff),
      .cfg       (cfg),
      .halt_cur  (halt_ff),
      .result    (result),
      .halt_next (halt_next)
   );

   assign req_setup.request_type   = req_tdata[7:0];
   assign req_setup.request_code   = req_tdata[15:8];
   assign req_setup.request_value  = req_tdata[31:16];
   assign req_setup.request_index  = req_tdata[47:32];
   assign req_setup.overflow_count = req_tdata[55:48];

   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign out_valid_in = s1_move ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   assign halt_in      = s1_move ? halt_next : halt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         halt_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         halt_ff      <= halt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_setup;
      end
      if (s1_move) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata[1:0]  = out_data_ff.reply_length;
   assign rsp_tdata[9:2]  = out_data_ff.reply_first;
   assign rsp_tdata[17:10] = out_data_ff.reply_second;
   assign rsp_tdata[25:18] = out_data_ff.descriptor_number;
   assign rsp_tdata[26]    = out_data_ff.clear_overflow;
   assign rsp_tdata[27]    = out_data_ff.reset_bulk_toggles;
   assign rsp_tdata[31:28] = 4'd0;
   assign rsp_tuser[0]     = out_data_ff.stall_control;
   assign rsp_tuser[3:1]   = out_data_ff.descriptor_kind;

endmodule

FILE: design/usbsrh_checker.sv
// ----------------------------------------------------------------------------
// usbsrh_checker
// Port-level checks of the USB standard request handler, bound to the top.
// ----------------------------------------------------------------------------
module usbsrh_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [usbsrh_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [usbsrh_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);
   import usbsrh_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_stall_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0 && rsp_tuser[3:1] == KIND_NONE)
      else $error("stalled result carries reply data");

   a_reply_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3 && rsp_tdata[17:10] == 8'd0)
      else $error("reply length or second byte out of range");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat valid right after reset");

endmodule

bind usb_standard_request_handler usbsrh_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
